### hw/rtl/bmmc_pkg.sv
// ============================================================================
// bmmc_pkg - shared types and constants of the banked memory map controller
// Bus commands, memory map regions, bank controller register codes and the
// fixed geometry of the map.
// ============================================================================
package bmmc_pkg;

    localparam int BANK_BYTES      = 16384;
    localparam int BANK_OFS_W      = 14;
    localparam int BANK_REG_W      = 7;
    localparam int COUNT_W         = 8;
    localparam int BLOCK_OFS_W     = 13;
    localparam int HIGH_OFS_W      = 9;
    localparam int VRAM_BYTES      = 8192;
    localparam int WRAM_BYTES      = 8192;
    localparam int HIGH_BYTES      = 512;
    localparam int CART_BANK_BYTES = 8192;
    localparam int APB_DW          = 32;

    localparam logic [7:0]  BANK_COUNT_RESET = 8'd2;
    localparam logic [3:0]  RAM_ENABLE_KEY   = 4'hA;
    localparam logic [15:0] HIGH_START       = 16'hFE00;
    localparam logic [1:0]  ADDR_BANK_COUNT  = 2'd0;

    typedef enum logic [1:0] {
        CMD_READ  = 2'd0,
        CMD_WRITE = 2'd1,
        CMD_LOAD  = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        RG_ROM,
        RG_VRAM,
        RG_CART,
        RG_WRAM,
        RG_HIGH
    } t_region;

    // Bank controller register selected by address bits 14:13 below 0x8000
    typedef enum logic [1:0] {
        MBC_RAM_EN = 2'd0,
        MBC_ROM_LO = 2'd1,
        MBC_ROM_HI = 2'd2,
        MBC_MODE   = 2'd3
    } t_mbc_reg;

    function automatic t_region region_of(input logic [15:0] addr);
        t_region rg;
        if (!addr[15]) begin
            rg = RG_ROM;
        end else if (addr[14:13] == 2'b00) begin
            rg = RG_VRAM;
        end else if (addr[14:13] == 2'b01) begin
            rg = RG_CART;
        end else if (addr >= HIGH_START) begin
            rg = RG_HIGH;
        end else begin
            rg = RG_WRAM;
        end
        return rg;
    endfunction

endpackage

### hw/rtl/bmmc_ram.sv
// ============================================================================
// bmmc_ram - generic single-port synchronous RAM
// One access per cycle; read data registered and held until the next read.
// ============================================================================
module bmmc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic             i_we,
    input  logic [AW-1:0]    i_addr,
    input  logic [WIDTH-1:0] i_wdata,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_we) begin
                r_mem[i_addr] <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_addr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/banked_memory_map_controller_top.sv
// ============================================================================
// banked_memory_map_controller_top - memory map with MBC1-style bank control
// Decodes 16-bit bus reads and writes, keeps the bank controller registers
// and holds the ROM store plus one combined RAM for cart, video, work and
// high memory.
// ============================================================================
// A write or a ROM load leaves nothing pending. A read holds the input off
// while it waits: the address goes to the synchronous RAM on the accepting
// edge, and the registered read data moves into the output register once
// that register is empty or being taken; no new transfer is accepted until
// the pending read has moved on. A write that touches the ROM bank bits
// (0x2000-0x5FFF) and any write of the bank count register start a bit-serial
// remainder unit that resolves the switchable bank; input is stalled
// meanwhile. After reset the combined RAM is swept to zero, one byte per
// cycle, over all CART_RAM_BYTES + 16896 bytes (49664 at the default size);
// no transfer is taken on the input channel during the sweep, while
// configuration writes are taken at any time. The ROM store is not cleared: a
// read from a ROM byte that was never loaded returns an undefined value.
// ============================================================================
module banked_memory_map_controller_top #(
    parameter int MAX_BANKS      = 128,
    parameter int CART_RAM_BYTES = 32768
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_command,
    input  logic [15:0] i_addr,
    input  logic [7:0]  i_data,
    input  logic [20:0] i_rom_load_addr,

    // result channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_read_data,

    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [1:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Geometry of the ROM store
    localparam int ROM_BYTES = MAX_BANKS * bmmc_pkg::BANK_BYTES;
    localparam int ROM_AW    = $clog2(ROM_BYTES);
    localparam int BANK_W    = $clog2(MAX_BANKS);
    localparam int OFS_W     = bmmc_pkg::BANK_OFS_W;
    localparam int CW        = bmmc_pkg::COUNT_W;
    localparam int BRW       = bmmc_pkg::BANK_REG_W;
    localparam int DWID      = bmmc_pkg::APB_DW;

    // Layout of the combined RAM: cart, video, work, high
    localparam int VRAM_BASE  = CART_RAM_BYTES;
    localparam int WRAM_BASE  = VRAM_BASE + bmmc_pkg::VRAM_BYTES;
    localparam int HIGH_BASE  = WRAM_BASE + bmmc_pkg::WRAM_BYTES;
    localparam int DATA_DEPTH = HIGH_BASE + bmmc_pkg::HIGH_BYTES;
    localparam int DW         = $clog2(DATA_DEPTH);

    // Cart RAM bank offsets, already wrapped to the cart size
    localparam int CSUM_W    = $clog2(2 * CART_RAM_BYTES);
    localparam int CART_OFS1 = (1 * bmmc_pkg::CART_BANK_BYTES) % CART_RAM_BYTES;
    localparam int CART_OFS2 = (2 * bmmc_pkg::CART_BANK_BYTES) % CART_RAM_BYTES;
    localparam int CART_OFS3 = (3 * bmmc_pkg::CART_BANK_BYTES) % CART_RAM_BYTES;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    // bank controller
    logic [BRW-1:0]    r_rom_bank,   n_rom_bank;
    logic [1:0]        r_ram_bank,   n_ram_bank;
    logic              r_ram_en,     n_ram_en;
    logic              r_mode,       n_mode;
    logic [CW-1:0]     r_bank_count, n_bank_count;
    // switchable bank remainder unit
    logic              r_div_busy,   n_div_busy;
    logic [2:0]        r_div_step,   n_div_step;
    logic [BRW-1:0]    r_div_rem,    n_div_rem;
    logic [BANK_W-1:0] r_cur_bank,   n_cur_bank;
    // clearing sweep
    logic              r_clr_busy,   n_clr_busy;
    logic [DW-1:0]     r_clr_addr,   n_clr_addr;
    // read in flight and output register
    logic              r_pend,       n_pend;
    logic              r_pend_rom,   n_pend_rom;
    logic              r_out_valid,  n_out_valid;
    logic [7:0]        r_out_data,   n_out_data;

    // ------------------------------------------------------------------
    // Handshakes and decode
    // ------------------------------------------------------------------
    logic                w_in_acc;
    logic                w_cfg_wr;
    logic                w_is_read;
    logic                w_is_write;
    logic                w_is_load;
    logic                w_load_ok;
    logic                w_bank_wr;
    bmmc_pkg::t_region   w_region;

    // Hold input off while the RAM is swept, the bank resolves or a read waits
    assign o_in_stall = r_clr_busy | r_div_busy | r_pend;
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel & penable & pwrite & pready
                    & (paddr == bmmc_pkg::ADDR_BANK_COUNT);
    assign prdata   = (paddr == bmmc_pkg::ADDR_BANK_COUNT)
                    ? DWID'(r_bank_count) : '0;

    assign w_region   = bmmc_pkg::region_of(i_addr);
    assign w_is_read  = (i_command == bmmc_pkg::CMD_READ);
    assign w_is_write = (i_command == bmmc_pkg::CMD_WRITE);
    assign w_is_load  = (i_command == bmmc_pkg::CMD_LOAD);
    assign w_load_ok  = ({1'b0, i_rom_load_addr} < 22'(ROM_BYTES));

    // ROM bank bits change only in the 0x2000-0x5FFF window
    assign w_bank_wr = w_in_acc & w_is_write & (w_region == bmmc_pkg::RG_ROM)
                     & (i_addr[14] ^ i_addr[13]);

    // ------------------------------------------------------------------
    // Bank remainder: one restoring step per cycle over the 7 bank bits
    // ------------------------------------------------------------------
    logic [CW-1:0]     w_count_eff;
    logic [CW-1:0]     w_rem_sh;
    logic [BRW-1:0]    w_rem_nx;
    logic [BANK_W-1:0] w_bank_val;

    // Clamp the bank count to the store size
    assign w_count_eff = (r_bank_count > CW'(MAX_BANKS)) ? CW'(MAX_BANKS) : r_bank_count;
    assign w_rem_sh    = {r_div_rem, r_rom_bank[r_div_step]};
    assign w_rem_nx    = (w_rem_sh >= w_count_eff) ? BRW'(w_rem_sh - w_count_eff)
                                                   : w_rem_sh[BRW-1:0];
    // Bank 0 in the switchable window becomes bank 1
    assign w_bank_val  = ((w_count_eff == '0) || (w_rem_nx == '0))
                       ? BANK_W'(1) : BANK_W'(w_rem_nx);

    // ------------------------------------------------------------------
    // Memory addressing
    // ------------------------------------------------------------------
    logic [CSUM_W-1:0] w_cart_base;
    logic [CSUM_W-1:0] w_cart_sum;
    logic [CSUM_W-1:0] w_cart_idx;
    logic [DW-1:0]     w_item_addr;
    logic              w_item_ram;

    logic              w_rom_en;
    logic [ROM_AW-1:0] w_rom_addr;
    logic [7:0]        w_rom_rdata;

    logic              w_data_en;
    logic              w_data_we;
    logic [DW-1:0]     w_data_addr;
    logic [7:0]        w_data_wdata;
    logic [7:0]        w_data_rdata;

    always_comb begin
        unique case (r_ram_bank)
            2'd0:    w_cart_base = '0;
            2'd1:    w_cart_base = CSUM_W'(CART_OFS1);
            2'd2:    w_cart_base = CSUM_W'(CART_OFS2);
            default: w_cart_base = CSUM_W'(CART_OFS3);
        endcase
    end

    // Offset below one 8 KiB block plus a wrapped base stays under twice the size
    assign w_cart_sum = w_cart_base + CSUM_W'(i_addr[bmmc_pkg::BLOCK_OFS_W-1:0]);
    assign w_cart_idx = (w_cart_sum >= CSUM_W'(CART_RAM_BYTES))
                      ? w_cart_sum - CSUM_W'(CART_RAM_BYTES) : w_cart_sum;

    always_comb begin
        w_item_addr = '0;
        w_item_ram  = 1'b0;
        unique case (w_region)
            bmmc_pkg::RG_VRAM: begin
                w_item_addr = DW'(VRAM_BASE) + DW'(i_addr[bmmc_pkg::BLOCK_OFS_W-1:0]);
                w_item_ram  = 1'b1;
            end
            bmmc_pkg::RG_CART: begin
                w_item_addr = DW'(w_cart_idx);
                // writes land only while cart RAM is enabled; reads always
                w_item_ram  = w_is_read | r_ram_en;
            end
            bmmc_pkg::RG_WRAM: begin
                // the echo region maps onto the same offsets
                w_item_addr = DW'(WRAM_BASE) + DW'(i_addr[bmmc_pkg::BLOCK_OFS_W-1:0]);
                w_item_ram  = 1'b1;
            end
            bmmc_pkg::RG_HIGH: begin
                w_item_addr = DW'(HIGH_BASE) + DW'(i_addr[bmmc_pkg::HIGH_OFS_W-1:0]);
                w_item_ram  = 1'b1;
            end
            default: begin
                w_item_addr = '0;
                w_item_ram  = 1'b0;
            end
        endcase
    end

    // ROM: loads write at the linear index, reads pick bank 0 or the switchable bank
    always_comb begin
        w_rom_en   = w_in_acc & ((w_is_load & w_load_ok)
                   | (w_is_read & (w_region == bmmc_pkg::RG_ROM)));
        if (w_is_load) begin
            w_rom_addr = i_rom_load_addr[ROM_AW-1:0];
        end else if (i_addr[OFS_W]) begin
            w_rom_addr = {r_cur_bank, i_addr[OFS_W-1:0]};
        end else begin
            w_rom_addr = ROM_AW'(i_addr[OFS_W-1:0]);
        end
    end

    // Combined RAM: the clearing sweep owns the port until it ends
    always_comb begin
        if (r_clr_busy) begin
            w_data_en    = 1'b1;
            w_data_we    = 1'b1;
            w_data_addr  = r_clr_addr;
            w_data_wdata = '0;
        end else begin
            w_data_en    = w_in_acc & (w_is_read | w_is_write) & w_item_ram;
            w_data_we    = w_is_write;
            w_data_addr  = w_item_addr;
            w_data_wdata = i_data;
        end
    end

    bmmc_ram #(
        .WIDTH (8),
        .DEPTH (ROM_BYTES)
    ) u_rom (
        .i_clk   (i_clk),
        .i_en    (w_rom_en),
        .i_we    (w_is_load),
        .i_addr  (w_rom_addr),
        .i_wdata (i_data),
        .o_rdata (w_rom_rdata)
    );

    bmmc_ram #(
        .WIDTH (8),
        .DEPTH (DATA_DEPTH)
    ) u_data_ram (
        .i_clk   (i_clk),
        .i_en    (w_data_en),
        .i_we    (w_data_we),
        .i_addr  (w_data_addr),
        .i_wdata (w_data_wdata),
        .o_rdata (w_data_rdata)
    );

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        n_rom_bank   = r_rom_bank;
        n_ram_bank   = r_ram_bank;
        n_ram_en     = r_ram_en;
        n_mode       = r_mode;
        n_bank_count = r_bank_count;
        n_div_busy   = r_div_busy;
        n_div_step   = r_div_step;
        n_div_rem    = r_div_rem;
        n_cur_bank   = r_cur_bank;
        n_clr_busy   = r_clr_busy;
        n_clr_addr   = r_clr_addr;
        n_pend       = r_pend;
        n_pend_rom   = r_pend_rom;
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;

        if (w_cfg_wr) begin
            n_bank_count = pwdata[CW-1:0];
        end

        // bank controller writes below 0x8000
        if (w_in_acc && w_is_write && (w_region == bmmc_pkg::RG_ROM)) begin
            unique case (bmmc_pkg::t_mbc_reg'(i_addr[14:13]))
                bmmc_pkg::MBC_RAM_EN: begin
                    n_ram_en = (i_data[3:0] == bmmc_pkg::RAM_ENABLE_KEY);
                end
                bmmc_pkg::MBC_ROM_LO: begin
                    n_rom_bank = {r_rom_bank[6:5],
                                  (i_data[4:0] == 5'd0) ? 5'd1 : i_data[4:0]};
                end
                bmmc_pkg::MBC_ROM_HI: begin
                    if (r_mode) begin
                        n_ram_bank = i_data[1:0];
                    end else begin
                        n_rom_bank = {i_data[1:0], r_rom_bank[4:0]};
                    end
                end
                bmmc_pkg::MBC_MODE: begin
                    n_mode = i_data[0];
                end
                default: begin
                    n_mode = r_mode;
                end
            endcase
        end

        // restart the remainder whenever its operands may have moved
        if (w_bank_wr || w_cfg_wr) begin
            n_div_busy = 1'b1;
            n_div_step = 3'(BRW - 1);
            n_div_rem  = '0;
        end else if (r_div_busy) begin
            n_div_rem  = w_rem_nx;
            n_div_step = r_div_step - 3'd1;
            if (r_div_step == 3'd0) begin
                n_div_busy = 1'b0;
                n_cur_bank = w_bank_val;
            end
        end

        // clearing sweep after reset
        if (r_clr_busy) begin
            n_clr_addr = r_clr_addr + DW'(1);
            if (r_clr_addr == DW'(DATA_DEPTH - 1)) begin
                n_clr_busy = 1'b0;
            end
        end

        // drop the output once it is taken; advance a waiting read into it
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end
        if (r_pend && (!r_out_valid || !i_out_stall)) begin
            n_out_valid = 1'b1;
            n_out_data  = r_pend_rom ? w_rom_rdata : w_data_rdata;
            n_pend      = 1'b0;
        end
        if (w_in_acc && w_is_read) begin
            n_pend     = 1'b1;
            n_pend_rom = (w_region == bmmc_pkg::RG_ROM);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rom_bank   <= BRW'(1);
            r_ram_bank   <= '0;
            r_ram_en     <= 1'b0;
            r_mode       <= 1'b0;
            r_bank_count <= bmmc_pkg::BANK_COUNT_RESET;
            r_div_busy   <= 1'b0;
            r_div_step   <= '0;
            r_cur_bank   <= BANK_W'(1);
            r_clr_busy   <= 1'b1;
            r_clr_addr   <= '0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_rom_bank   <= n_rom_bank;
            r_ram_bank   <= n_ram_bank;
            r_ram_en     <= n_ram_en;
            r_mode       <= n_mode;
            r_bank_count <= n_bank_count;
            r_div_busy   <= n_div_busy;
            r_div_step   <= n_div_step;
            r_cur_bank   <= n_cur_bank;
            r_clr_busy   <= n_clr_busy;
            r_clr_addr   <= n_clr_addr;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_div_rem  <= n_div_rem;
        r_pend_rom <= n_pend_rom;
        r_out_data <= n_out_data;
    end

    assign o_out_valid = r_out_valid;
    assign o_read_data = r_out_data;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_read_pends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_is_read |=> r_pend)
        else $error("accepted read left no pending result");

    a_bank_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur_bank != '0)
        else $error("switchable bank resolved to zero");

    a_bank_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_div_busy && (w_count_eff > CW'(1)) |-> CW'(r_cur_bank) < w_count_eff)
        else $error("switchable bank not below bank count");

    a_rom_low_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rom_bank[4:0] != 5'd0)
        else $error("low ROM bank bits hold zero");

    a_sweep_complete: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(r_clr_busy) |-> $past(r_clr_addr) == DW'(DATA_DEPTH - 1))
        else $error("clearing sweep ended early");

endmodule
